// ===== hdl/vfa_pkg.sv =====
package vfa_pkg;

    // Word format and derived widths.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SQRT_STEPS = DATA_WIDTH;
    localparam int SQRT_REM_W = DATA_WIDTH + 4;
    localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_REM_W  = DATA_WIDTH + 1;
    localparam int LANES      = 3;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_SCALE  = 4'd2,
        OP_DIV    = 4'd3,
        OP_DOT    = 4'd4,
        OP_CROSS  = 4'd5,
        OP_LENGTH = 4'd6,
        OP_NORM   = 4'd7,
        OP_EQUAL  = 4'd8
    } op_t;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        op_t   op;
        word_t a_x;
        word_t a_y;
        word_t a_z;
        word_t b_x;
        word_t b_y;
        word_t b_z;
        word_t scalar_in;
    } in_t;

    typedef struct packed {
        word_t r_x;
        word_t r_y;
        word_t r_z;
        word_t r_scalar;
        logic  equal_flag;
        logic  zero_div_flag;
    } out_t;

    // Operands of one lane, rotated so that lane i sees component i first.
    typedef struct packed {
        op_t   op;
        word_t ai;
        word_t aj;
        word_t ak;
        word_t bi;
        word_t bj;
        word_t bk;
        word_t s;
    } lane_in_t;

    // Data that rides along with an item through the root and divide pipelines.
    typedef struct packed {
        op_t                             op;
        logic [LANES-1:0][DATA_WIDTH-1:0] a;
        word_t                           s;
        logic [DATA_WIDTH-1:0]           len;
        out_t                            res;
    } side_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Saturate a wide signed value to one word.
    function automatic logic [DATA_WIDTH-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_MAX)
            return WORD_MAX;
        else if (v < ACC_MIN)
            return WORD_MIN;
        else
            return v[DATA_WIDTH-1:0];
    endfunction

    // Floor the fraction bits away, then saturate.
    function automatic logic [DATA_WIDTH-1:0] fix_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v >>> FRAC_BITS;
        return sat_acc(t);
    endfunction

    // Magnitude of a signed word as an unsigned word.
    function automatic logic [DATA_WIDTH-1:0] mag(input word_t v);
        if (v[DATA_WIDTH-1])
            return ~v + 1'b1;
        else
            return v;
    endfunction

endpackage

// ===== hdl/vfa_lane.sv =====
module vfa_lane (
    input  logic                                clk,
    input  vfa_pkg::lane_in_t                   opnd,
    output logic signed [vfa_pkg::PROD_W-1:0]   p0,
    output logic signed [vfa_pkg::PROD_W-1:0]   p1
);
    import vfa_pkg::*;

    word_t x0;
    word_t y0;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;

    // Operand select for the main multiplier.
    always_comb
    begin
        case (opnd.op) inside
            OP_CROSS:
            begin
                x0 = opnd.aj;
                y0 = opnd.bk;
            end
            OP_SCALE:
            begin
                x0 = opnd.ai;
                y0 = opnd.s;
            end
            OP_LENGTH, OP_NORM:
            begin
                x0 = opnd.ai;
                y0 = opnd.ai;
            end
            default:
            begin
                x0 = opnd.ai;
                y0 = opnd.bi;
            end
        endcase
    end

    // Two registered products; the second one serves the cross product only.
    always_ff @(posedge clk)
    begin
        p0_reg <= x0 * y0;
        p1_reg <= opnd.ak * opnd.bj;
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;

endmodule

// ===== hdl/vfa_sqrt.sv =====
module vfa_sqrt (
    input  logic                              clk,
    input  logic [vfa_pkg::PROD_W-1:0]        radicand,
    output logic [vfa_pkg::DATA_WIDTH-1:0]    root
);
    import vfa_pkg::*;

    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [DATA_WIDTH-1:0] root_reg [SQRT_STEPS];
    logic [PROD_W-1:0]     n_reg    [SQRT_STEPS];

    // One root bit per stage, restoring digit-by-digit method.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_stage
        logic [SQRT_REM_W-1:0] rem_prev;
        logic [DATA_WIDTH-1:0] root_prev;
        logic [PROD_W-1:0]     n_prev;
        logic [SQRT_REM_W-1:0] cand;
        logic [SQRT_REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign n_prev    = radicand;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign n_prev    = n_reg[k-1];
        end

        assign cand  = {rem_prev[SQRT_REM_W-3:0], n_prev[PROD_W-1:PROD_W-2]};
        assign trial = SQRT_REM_W'({root_prev, 2'b01});

        always_ff @(posedge clk)
        begin
            n_reg[k] <= {n_prev[PROD_W-3:0], 2'b00};
            if (cand >= trial)
            begin
                rem_reg[k]  <= cand - trial;
                root_reg[k] <= {root_prev[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= cand;
                root_reg[k] <= {root_prev[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ===== hdl/vfa_div.sv =====
module vfa_div (
    input  logic                              clk,
    input  logic [vfa_pkg::DIV_STEPS-1:0]     dividend,
    input  logic [vfa_pkg::DATA_WIDTH-1:0]    divisor,
    output logic [vfa_pkg::DIV_STEPS-1:0]     quotient
);
    import vfa_pkg::*;

    logic [DIV_REM_W-1:0]  rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0]  sh_reg  [DIV_STEPS];
    logic [DATA_WIDTH-1:0] d_reg   [DIV_STEPS];

    // One quotient bit per stage; dividend bits shift out the top while
    // quotient bits shift in at the bottom of the same register.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_stage
        logic [DIV_REM_W-1:0]  rem_prev;
        logic [DIV_STEPS-1:0]  sh_prev;
        logic [DATA_WIDTH-1:0] d_prev;
        logic [DIV_REM_W-1:0]  cand;
        logic                  fits;

        if (k == 0)
        begin : g_first
            assign rem_prev = '0;
            assign sh_prev  = dividend;
            assign d_prev   = divisor;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign sh_prev  = sh_reg[k-1];
            assign d_prev   = d_reg[k-1];
        end

        assign cand = {rem_prev[DIV_REM_W-2:0], sh_prev[DIV_STEPS-1]};
        assign fits = (cand >= {1'b0, d_prev});

        always_ff @(posedge clk)
        begin
            d_reg[k]   <= d_prev;
            sh_reg[k]  <= {sh_prev[DIV_STEPS-2:0], fits};
            rem_reg[k] <= fits ? (cand - {1'b0, d_prev}) : cand;
        end
    end

    assign quotient = sh_reg[DIV_STEPS-1];

endmodule

// ===== hdl/vec3_fixed_point_alu_core.sv =====
// Channel  | Signals                   | Handshake
// ---------+---------------------------+------------------------------------
// command  | start, busy, din (in_t)   | beat taken when start && !busy
// result   | done, dout (out_t)        | beat shown for one cycle with done
//
// Fully pipelined: one command beat per clock, busy is always low.
// Every opcode takes the same path: the lane product registers, the merge register,
// the one-bit-per-stage square root (32 stages), the one-bit-per-stage divider
// (48 stages) that every beat passes through, and the output register.
// rst_n clears only the valid pipeline; results come out in command order.
// The receiver cannot stall, so the pipeline never holds.
module vec3_fixed_point_alu_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vfa_pkg::in_t  din,
    output logic          done,
    output vfa_pkg::out_t dout
);
    import vfa_pkg::*;

    logic accept;
    logic [LANES-1:0][DATA_WIDTH-1:0] a_in;
    logic [LANES-1:0][DATA_WIDTH-1:0] b_in;
    logic signed [PROD_W-1:0] p0 [LANES];
    logic signed [PROD_W-1:0] p1 [LANES];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign a_in   = {din.a_z, din.a_y, din.a_x};
    assign b_in   = {din.b_z, din.b_y, din.b_x};

    // Multiplier lanes, one per component.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        lane_in_t lin;

        assign lin.op = din.op;
        assign lin.ai = a_in[i];
        assign lin.aj = a_in[(i+1)%LANES];
        assign lin.ak = a_in[(i+2)%LANES];
        assign lin.bi = b_in[i];
        assign lin.bj = b_in[(i+1)%LANES];
        assign lin.bk = b_in[(i+2)%LANES];
        assign lin.s  = din.scalar_in;

        vfa_lane u_lane (
            .clk  (clk),
            .opnd (lin),
            .p0   (p0[i]),
            .p1   (p1[i])
        );
    end

    // Stage 1: operands ride beside the products.
    logic                              v1_reg;
    op_t                               op1_reg;
    logic [LANES-1:0][DATA_WIDTH-1:0]  a1_reg;
    logic [LANES-1:0][DATA_WIDTH-1:0]  b1_reg;
    word_t                             s1_reg;
    logic                              eq1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= din.op;
        a1_reg  <= a_in;
        b1_reg  <= b_in;
        s1_reg  <= din.scalar_in;
        eq1_reg <= (a_in == b_in);
    end

    // Stage 2: merge the lanes and finish the single-pass opcodes.
    logic signed [ACC_W-1:0]          dot_sum;
    logic [LANES-1:0][DATA_WIDTH-1:0] rv2;
    side_t                            side2;
    logic                             v2_reg;
    side_t                            side2_reg;
    logic [PROD_W-1:0]                sumsq2_reg;

    assign dot_sum = ACC_W'(p0[0]) + ACC_W'(p0[1]) + ACC_W'(p0[2]);

    always_comb
    begin
        rv2 = '0;
        side2 = '0;
        side2.op = op1_reg;
        side2.a  = a1_reg;
        side2.s  = s1_reg;
        for (int i = 0; i < LANES; i++)
        begin
            case (op1_reg)
                OP_ADD:
                    rv2[i] = sat_acc(ACC_W'($signed(a1_reg[i])) + ACC_W'($signed(b1_reg[i])));
                OP_SUB:
                    rv2[i] = sat_acc(ACC_W'($signed(a1_reg[i])) - ACC_W'($signed(b1_reg[i])));
                OP_SCALE:
                    rv2[i] = fix_acc(ACC_W'(p0[i]));
                OP_CROSS:
                    rv2[i] = fix_acc(ACC_W'(p0[i]) - ACC_W'(p1[i]));
                default:
                    rv2[i] = '0;
            endcase
        end
        side2.res.r_x = rv2[0];
        side2.res.r_y = rv2[1];
        side2.res.r_z = rv2[2];
        if (op1_reg == OP_DOT)
            side2.res.r_scalar = fix_acc(dot_sum);
        if (op1_reg == OP_EQUAL)
            side2.res.equal_flag = eq1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        side2_reg  <= side2;
        sumsq2_reg <= dot_sum[PROD_W-1:0];
    end

    // Square root of the sum of squares, with the side data delayed to match.
    logic [DATA_WIDTH-1:0] len_sq;
    side_t                 sq_line_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sq_vld_reg;

    vfa_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sumsq2_reg),
        .root     (len_sq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= '0;
        else
            sq_vld_reg <= {sq_vld_reg[SQRT_STEPS-2:0], v2_reg};
    end

    always_ff @(posedge clk)
    begin
        sq_line_reg[0] <= side2_reg;
        for (int k = 1; k < SQRT_STEPS; k++)
            sq_line_reg[k] <= sq_line_reg[k-1];
    end

    // Divider entry: divisor is the scalar or the length.
    side_t                 side_s;
    logic [DATA_WIDTH-1:0] den;
    logic [DIV_STEPS-1:0]  quot [LANES];

    always_comb
    begin
        side_s     = sq_line_reg[SQRT_STEPS-1];
        side_s.len = len_sq;
        den        = (side_s.op == OP_DIV) ? mag(side_s.s) : len_sq;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        vfa_div u_div (
            .clk      (clk),
            .dividend ({mag(side_s.a[i]), {FRAC_BITS{1'b0}}}),
            .divisor  (den),
            .quotient (quot[i])
        );
    end

    side_t                dv_line_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg <= '0;
        else
            dv_vld_reg <= {dv_vld_reg[DIV_STEPS-2:0], sq_vld_reg[SQRT_STEPS-1]};
    end

    always_ff @(posedge clk)
    begin
        dv_line_reg[0] <= side_s;
        for (int k = 1; k < DIV_STEPS; k++)
            dv_line_reg[k] <= dv_line_reg[k-1];
    end

    // Signed, saturated quotient from an unsigned one.
    function automatic logic [DATA_WIDTH-1:0] fix_quot(input logic [DIV_STEPS-1:0] q,
                                                       input logic neg);
        if (q[DIV_STEPS-1:DATA_WIDTH-1] != '0)
            return neg ? WORD_MIN : WORD_MAX;
        else if (neg)
            return ~q[DATA_WIDTH-1:0] + 1'b1;
        else
            return q[DATA_WIDTH-1:0];
    endfunction

    // Final stage: pick the result of the opcode.
    side_t                            side_f;
    logic [LANES-1:0][DATA_WIDTH-1:0] rvf;
    out_t                             res_f;
    logic                             done_reg;
    out_t                             dout_reg;

    always_comb
    begin
        side_f = dv_line_reg[DIV_STEPS-1];
        res_f  = side_f.res;
        rvf    = '0;
        case (side_f.op)
            OP_DIV:
            begin
                if (side_f.s == '0)
                    res_f.zero_div_flag = 1'b1;
                else
                    for (int i = 0; i < LANES; i++)
                        rvf[i] = fix_quot(quot[i], side_f.a[i][DATA_WIDTH-1] ^
                                                   side_f.s[DATA_WIDTH-1]);
                res_f.r_x = rvf[0];
                res_f.r_y = rvf[1];
                res_f.r_z = rvf[2];
            end
            OP_LENGTH:
                res_f.r_scalar = side_f.len[DATA_WIDTH-1] ? WORD_MAX : side_f.len;
            OP_NORM:
            begin
                if (side_f.len == '0)
                begin
                    res_f.zero_div_flag = 1'b1;
                    rvf = side_f.a;
                end
                else
                    for (int i = 0; i < LANES; i++)
                        rvf[i] = fix_quot(quot[i], side_f.a[i][DATA_WIDTH-1]);
                res_f.r_x = rvf[0];
                res_f.r_y = rvf[1];
                res_f.r_z = rvf[2];
            end
            default:
                res_f = side_f.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_vld_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= res_f;
    end

    assign done = done_reg;
    assign dout = dout_reg;

endmodule
